### hdl/assert_macros.svh
// Assertion macros shared by the modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge while reset is released.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/pwe_pkg.sv
// Types and fixed constants of the polyline width extruder.
package pwe_pkg;

    // Stroke width register.
    localparam int WIDTH_W = 16;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd256;

    // Segment magnitudes are prescaled below 2^MAG_W.
    localparam int MAG_W = 15;
    localparam int MUL_W = 16;
    localparam int PROD_W = 2 * MUL_W;
    localparam int LEN2_W = 31;

    // Square root of len2 * 2^RAD_SHIFT, two radicand bits per step.
    localparam int RAD_SHIFT = 16;
    localparam int RAD_W = 48;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 3;
    localparam int SQRT_STEPS = ROOT_W;

    // Quotient and numerator widths grow with the fraction bits.
    localparam int QUO_EXTRA = 9;
    localparam int NUM_EXTRA = 32;

    localparam int MUL_STEPS = 4;
    localparam int BEATS = 4;
    localparam int CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIFF,
        S_SCALE,
        S_MUL,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_OFFS,
        S_OUT
    } state_t;

    // Operand pair for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_XX,
        MUL_YY,
        MUL_WY,
        MUL_WX
    } mul_sel_t;

    // Strip vertex emitted on an output beat.
    typedef enum logic [1:0] {
        BEAT_PREV,
        BEAT_PREV_OFF,
        BEAT_CUR,
        BEAT_CUR_OFF
    } beat_t;

    typedef struct packed {
        logic     accept;
        logic     diff;
        logic     scale_step;
        logic     mul_step;
        mul_sel_t mul_sel;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     offs;
        logic     emit;
        beat_t    beat;
        logic     finish;
    } pwe_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic zero_seg;
        logic scale_done;
        logic out_free;
    } pwe_sts_t;

endpackage

### hdl/polyline_width_extruder_top.sv
// Top level of the polyline width extruder: stream ports, controller and datapath.
//
// Each polyline vertex that follows another vertex of the same polyline yields four
// strip vertices: the previous vertex, the previous vertex pushed out along the left
// normal by the stroke width, the current vertex, and the current vertex pushed out
// the same way (tlast set on that fourth beat). A vertex is taken only while the
// block is idle; the segment then runs through a prescaler (one bit shift a cycle),
// four shared-multiplier steps, a 24-step square root and FRAC_BITS + 9 division
// steps before its four output beats. The prescaler makes 0 to COORD_BITS - 15
// shifts. A zero-length segment skips the multiplier, square root and division, and
// the first vertex of a polyline is only stored and yields no output.
// Output stalls stretch the beat phase only.
module polyline_width_extruder_top #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [15:0]                        cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // pos_x, pos_y, vertex_color from bit 0 up, zero filled to whole bytes
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x, out_y, out_color from bit 0 up, zero filled to whole bytes
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast
);
    import pwe_pkg::*;

    `include "assert_macros.svh"

    localparam int CB     = COORD_BITS;
    localparam int DATA_W = ((2 * CB + 32 + 7) / 8) * 8;

    pwe_cmd_t              cmd;
    pwe_sts_t              sts;
    logic signed [CB-1:0]  out_x;
    logic signed [CB-1:0]  out_y;
    logic [31:0]           out_color;

    pwe_ctrl #(
        .DIV_STEPS (FRAC_BITS + QUO_EXTRA)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pwe_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .pos_x        (s_tdata[CB-1:0]),
        .pos_y        (s_tdata[2*CB-1:CB]),
        .vertex_color (s_tdata[2*CB+31:2*CB]),
        .ends_line    (s_tlast),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_color    (out_color),
        .run_last     (m_tlast),
        .cmd          (cmd),
        .sts          (sts)
    );

    // Pack the output beat.
    assign m_tdata = DATA_W'({out_color, out_y, out_x});

    // A new beat never overwrites one that is still waiting.
    `ASSERT_CLK(a_emit_free, cmd.emit |-> (!m_tvalid || m_tready), "beat overwritten")

    // The fourth strip vertex shows up with tlast on the next cycle.
    `ASSERT_CLK(a_last_beat, cmd.emit && cmd.beat == BEAT_CUR_OFF |=> m_tvalid && m_tlast, "tlast missing on fourth beat")

    // A vertex that starts a segment closes the input until its beats are out.
    `ASSERT_CLK(a_busy_after_accept, s_tvalid && s_tready && sts.have_prev |=> !s_tready, "input open during segment work")

    // No arithmetic or output step runs while the input is open.
    `ASSERT_ALWAYS(a_idle_quiet, s_tready |-> !cmd.emit && !cmd.sqrt_step && !cmd.div_step, "datapath busy while idle")

endmodule

### hdl/pwe_ctrl.sv
// Controller state machine that sequences the extruder datapath.
module pwe_ctrl #(
    parameter int DIV_STEPS = 17
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pwe_pkg::pwe_sts_t sts,
    output pwe_pkg::pwe_cmd_t cmd
);
    import pwe_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             advance;
    logic             emit;

    assign emit = (state_reg == S_OUT) && sts.out_free;

    // State and step counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && sts.have_prev)
                    state_next = S_DIFF;
            end
            S_DIFF:
                state_next = S_SCALE;
            S_SCALE:
            begin
                if (sts.zero_seg)
                    state_next = S_OFFS;
                else if (sts.scale_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    state_next = S_SQRT;
            end
            S_SQRT:
            begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    state_next = S_DINIT;
            end
            S_DINIT:
                state_next = S_DIV;
            S_DIV:
            begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_OFFS;
            end
            S_OFFS:
                state_next = S_OUT;
            S_OUT:
            begin
                if (emit && cnt_reg == CNT_W'(BEATS - 1))
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // The counter restarts in every state and counts steps or beats.
    always_comb
    begin
        advance = (state_reg == S_MUL) || (state_reg == S_SQRT) ||
                  (state_reg == S_DIV) || emit;
        if (state_next != state_reg)
            cnt_next = '0;
        else if (advance)
            cnt_next = cnt_reg + 1'b1;
        else
            cnt_next = cnt_reg;
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = mul_sel_t'(cnt_reg[1:0]);
        cmd.beat       = beat_t'(cnt_reg[1:0]);
        s_tready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_DIFF:
                cmd.diff = 1'b1;
            S_SCALE:
                cmd.scale_step = !sts.zero_seg && !sts.scale_done;
            S_MUL:
            begin
                cmd.mul_step  = 1'b1;
                cmd.sqrt_init = (cnt_reg == CNT_W'(MUL_STEPS - 1));
            end
            S_SQRT:
                cmd.sqrt_step = 1'b1;
            S_DINIT:
                cmd.div_init = 1'b1;
            S_DIV:
                cmd.div_step = 1'b1;
            S_OFFS:
                cmd.offs = 1'b1;
            S_OUT:
            begin
                cmd.emit   = emit;
                cmd.finish = emit && (cnt_reg == CNT_W'(BEATS - 1));
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

### hdl/pwe_datapath.sv
// Datapath: vertex registers, prescaler, shared multiplier, square root,
// two division lanes, saturating offsets and the output register.
module pwe_datapath #(
    parameter int COORD_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [pwe_pkg::WIDTH_W-1:0]    cfg_wdata,
    input  logic signed [COORD_BITS-1:0]   pos_x,
    input  logic signed [COORD_BITS-1:0]   pos_y,
    input  logic [31:0]                    vertex_color,
    input  logic                           ends_line,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic signed [COORD_BITS-1:0]   out_x,
    output logic signed [COORD_BITS-1:0]   out_y,
    output logic [31:0]                    out_color,
    output logic                           run_last,
    input  pwe_pkg::pwe_cmd_t              cmd,
    output pwe_pkg::pwe_sts_t              sts
);
    import pwe_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int AX_W  = (CB + 1 > MUL_W) ? CB + 1 : MUL_W;
    localparam int QUO_W = FRAC_BITS + QUO_EXTRA;
    localparam int NUM_W = FRAC_BITS + NUM_EXTRA;
    localparam int OFF_W = QUO_W + 1;
    localparam int SUM_W = ((CB > OFF_W) ? CB : OFF_W) + 1;
    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((64'sd1 <<< (CB - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    // Saturating add of an offset to a coordinate.
    function automatic logic signed [CB-1:0] sat_add(
        input logic signed [CB-1:0]    base,
        input logic signed [OFF_W-1:0] off
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s > SMAX)
            return CB'(SMAX);
        else if (s < SMIN)
            return CB'(SMIN);
        else
            return CB'(s);
    endfunction

    // One restoring division step: shift in a dividend bit, try the divisor.
    function automatic logic [ROOT_W+QUO_W-1:0] div_step_f(
        input logic [ROOT_W-1:0] rem,
        input logic [QUO_W-1:0]  quo,
        input logic [ROOT_W-1:0] den
    );
        logic [ROOT_W:0] t;
        logic            ge;
        t  = {rem, quo[QUO_W-1]};
        ge = (t >= {1'b0, den});
        if (ge)
            return {ROOT_W'(t - {1'b0, den}), quo[QUO_W-2:0], 1'b1};
        else
            return {ROOT_W'(t), quo[QUO_W-2:0], 1'b0};
    endfunction

    logic [WIDTH_W-1:0]    width_reg;
    logic signed [CB-1:0]  prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [31:0]           prev_color_reg, cur_color_reg;
    logic                  cur_ends_reg;
    logic                  have_prev_reg;
    logic [AX_W-1:0]       ax_reg, ay_reg;
    logic                  dx_pos_reg, dy_pos_reg;
    logic [PROD_W-1:0]     prod_xx_reg, prod_yy_reg, prod_wy_reg, prod_wx_reg;
    logic [LEN2_W-1:0]     len2_reg;
    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      srem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_W-1:0]     rem_x_reg, rem_y_reg;
    logic [QUO_W-1:0]      quo_x_reg, quo_y_reg;
    logic signed [CB-1:0]  poff_x_reg, poff_y_reg, coff_x_reg, coff_y_reg;
    logic                  m_tvalid_reg;
    logic signed [CB-1:0]  out_x_reg, out_y_reg;
    logic [31:0]           out_color_reg;
    logic                  run_last_reg;

    logic signed [CB:0]    dx, dy;
    logic [CB:0]           adx, ady;
    logic [MUL_W-1:0]      mul_a, mul_b;
    logic [PROD_W-1:0]     prod;
    logic [REM_W-1:0]      srem_shift, strial;
    logic [NUM_W-1:0]      num_x, num_y;
    logic [ROOT_W+QUO_W-1:0] step_x, step_y;
    logic signed [OFF_W-1:0] off_x, off_y;
    logic                  zero_seg;

    // Status back to the controller.
    assign zero_seg = (ax_reg == '0) && (ay_reg == '0);
    assign sts.have_prev  = have_prev_reg;
    assign sts.zero_seg   = zero_seg;
    assign sts.scale_done = (ax_reg[AX_W-1:MAG_W] == '0) && (ay_reg[AX_W-1:MAG_W] == '0);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    // Stroke width register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            width_reg <= WIDTH_RESET;
        else if (cfg_we)
            width_reg <= cfg_wdata;
    end

    // Previous vertex and its presence flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_color_reg <= '0;
        end
        else if (cmd.accept && !have_prev_reg)
        begin
            have_prev_reg  <= !ends_line;
            prev_x_reg     <= pos_x;
            prev_y_reg     <= pos_y;
            prev_color_reg <= vertex_color;
        end
        else if (cmd.finish)
        begin
            have_prev_reg  <= !cur_ends_reg;
            prev_x_reg     <= cur_x_reg;
            prev_y_reg     <= cur_y_reg;
            prev_color_reg <= cur_color_reg;
        end
    end

    // Current vertex.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && have_prev_reg)
        begin
            cur_x_reg     <= pos_x;
            cur_y_reg     <= pos_y;
            cur_color_reg <= vertex_color;
            cur_ends_reg  <= ends_line;
        end
    end

    // Segment difference and magnitudes.
    always_comb
    begin
        dx  = (CB + 1)'(cur_x_reg) - (CB + 1)'(prev_x_reg);
        dy  = (CB + 1)'(cur_y_reg) - (CB + 1)'(prev_y_reg);
        adx = dx[CB] ? (CB + 1)'(-dx) : (CB + 1)'(dx);
        ady = dy[CB] ? (CB + 1)'(-dy) : (CB + 1)'(dy);
    end

    // Magnitudes load from the difference, then shift until both fit.
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            ax_reg     <= AX_W'(adx);
            ay_reg     <= AX_W'(ady);
            dx_pos_reg <= !dx[CB] && (dx != '0);
            dy_pos_reg <= !dy[CB] && (dy != '0);
        end
        else if (cmd.scale_step)
        begin
            ax_reg <= ax_reg >> 1;
            ay_reg <= ay_reg >> 1;
        end
    end

    // Shared multiplier, one product per step.
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_XX:
            begin
                mul_a = ax_reg[MUL_W-1:0];
                mul_b = ax_reg[MUL_W-1:0];
            end
            MUL_YY:
            begin
                mul_a = ay_reg[MUL_W-1:0];
                mul_b = ay_reg[MUL_W-1:0];
            end
            MUL_WY:
            begin
                mul_a = width_reg;
                mul_b = ay_reg[MUL_W-1:0];
            end
            MUL_WX:
            begin
                mul_a = width_reg;
                mul_b = ax_reg[MUL_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_step)
        begin
            case (cmd.mul_sel)
                MUL_XX: prod_xx_reg <= prod;
                MUL_YY: prod_yy_reg <= prod;
                MUL_WY:
                begin
                    prod_wy_reg <= prod;
                    len2_reg    <= LEN2_W'(prod_xx_reg + prod_yy_reg);
                end
                default: prod_wx_reg <= prod;
            endcase
        end
    end

    // Digit-by-digit square root, two radicand bits per step.
    always_comb
    begin
        srem_shift = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        strial     = REM_W'({root_reg, 2'b01});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            rad_reg  <= RAD_W'({len2_reg, {RAD_SHIFT{1'b0}}});
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (srem_shift >= strial)
            begin
                srem_reg <= srem_shift - strial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Two division lanes share the length as divisor; dividends round half up.
    always_comb
    begin
        num_x  = (NUM_W'(prod_wy_reg) << FRAC_BITS) + NUM_W'(root_reg >> 1);
        num_y  = (NUM_W'(prod_wx_reg) << FRAC_BITS) + NUM_W'(root_reg >> 1);
        step_x = div_step_f(rem_x_reg, quo_x_reg, root_reg);
        step_y = div_step_f(rem_y_reg, quo_y_reg, root_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_x_reg <= ROOT_W'(num_x[NUM_W-1:QUO_W]);
            quo_x_reg <= num_x[QUO_W-1:0];
            rem_y_reg <= ROOT_W'(num_y[NUM_W-1:QUO_W]);
            quo_y_reg <= num_y[QUO_W-1:0];
        end
        else if (cmd.div_step)
        begin
            {rem_x_reg, quo_x_reg} <= step_x;
            {rem_y_reg, quo_y_reg} <= step_y;
        end
    end

    // Signed offsets along the left normal, zero for a degenerate segment.
    always_comb
    begin
        if (zero_seg)
        begin
            off_x = '0;
            off_y = '0;
        end
        else
        begin
            off_x = dy_pos_reg ? -OFF_W'(quo_x_reg) : OFF_W'(quo_x_reg);
            off_y = dx_pos_reg ? OFF_W'(quo_y_reg) : -OFF_W'(quo_y_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.offs)
        begin
            poff_x_reg <= sat_add(prev_x_reg, off_x);
            poff_y_reg <= sat_add(prev_y_reg, off_y);
            coff_x_reg <= sat_add(cur_x_reg, off_x);
            coff_y_reg <= sat_add(cur_y_reg, off_y);
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.emit)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Output register payload, one strip vertex per beat.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            case (cmd.beat)
                BEAT_PREV:
                begin
                    out_x_reg     <= prev_x_reg;
                    out_y_reg     <= prev_y_reg;
                    out_color_reg <= prev_color_reg;
                    run_last_reg  <= 1'b0;
                end
                BEAT_PREV_OFF:
                begin
                    out_x_reg     <= poff_x_reg;
                    out_y_reg     <= poff_y_reg;
                    out_color_reg <= prev_color_reg;
                    run_last_reg  <= 1'b0;
                end
                BEAT_CUR:
                begin
                    out_x_reg     <= cur_x_reg;
                    out_y_reg     <= cur_y_reg;
                    out_color_reg <= cur_color_reg;
                    run_last_reg  <= 1'b0;
                end
                default:
                begin
                    out_x_reg     <= coff_x_reg;
                    out_y_reg     <= coff_y_reg;
                    out_color_reg <= cur_color_reg;
                    run_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid  = m_tvalid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_color = out_color_reg;
    assign run_last  = run_last_reg;

endmodule

### dv/tb_top.sv
// Self-checking testbench of the polyline width extruder with an in-line strip predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS = 8;
    localparam int DATA_W = ((2 * COORD_BITS + 32 + 7) / 8) * 8;
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (COORD_BITS - 1));
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;

    // One polyline vertex as offered on the input stream.
    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [31:0]                  color;
        logic                         ends;
    } vertex_t;

    // One triangle-strip vertex as expected on the output stream.
    typedef struct {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [31:0]           color;
        logic                  last;
    } strip_vtx_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [15:0]       cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // pos_x, pos_y, vertex_color from bit 0 up
    logic [DATA_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // out_x, out_y, out_color from bit 0 up
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    vertex_t    vertex_queue[$];
    strip_vtx_t strip_expect[$];

    // Predictor copy of the block state and the stroke width.
    logic [15:0]                  stroke_w = 16'd256;
    logic signed [COORD_BITS-1:0] last_x = '0;
    logic signed [COORD_BITS-1:0] last_y = '0;
    logic [31:0]                  last_color = '0;
    logic                         have_prev = 1'b0;

    // Handshake bookkeeping shared between the clocked processes.
    logic       src_fire = 1'b0;
    logic       snk_fire = 1'b0;
    logic       src_idle_en = 1'b1;
    logic       snk_idle_en = 1'b1;
    int         src_gap = 0;
    int         snk_wait = 0;
    int         hold_requests = 0;
    int         hold_served = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         mismatch_count = 0;
    vertex_t    pending;
    vertex_t    seen_vtx;
    strip_vtx_t want;

    polyline_width_extruder_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Bit-by-bit integer square root, floor of the exact root.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic strip_vtx_t strip_vtx(input longint x, input longint y,
                                             input logic [31:0] color, input logic last);
        strip_vtx_t s;
        s.x = x[COORD_BITS-1:0];
        s.y = y[COORD_BITS-1:0];
        s.color = color;
        s.last = last;
        return s;
    endfunction

    // Extrude one accepted vertex: four strip vertices once a previous vertex exists.
    function automatic void extrude_vertex(input vertex_t v);
        longint          cx;
        longint          cy;
        longint          px;
        longint          py;
        longint          dx;
        longint          dy;
        longint          offx;
        longint          offy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned len;
        longint unsigned mx;
        longint unsigned my;
        cx = v.x;
        cy = v.y;
        px = last_x;
        py = last_y;
        if (have_prev)
        begin
            dx = cx - px;
            dy = cy - py;
            offx = 0;
            offy = 0;
            // A zero-length segment keeps the offset at zero.
            if (dx != 0 || dy != 0)
            begin
                ax = (dx < 0) ? -dx : dx;
                ay = (dy < 0) ? -dy : dy;
                while (ax >= 32768 || ay >= 32768)
                begin
                    ax = ax >> 1;
                    ay = ay >> 1;
                end
                len = floor_sqrt((ax * ax + ay * ay) << 16);
                mx = (((longint'(stroke_w) * ay) << FRAC_BITS) + (len >> 1)) / len;
                my = (((longint'(stroke_w) * ax) << FRAC_BITS) + (len >> 1)) / len;
                offx = (dy > 0) ? -longint'(mx) : longint'(mx);
                offy = (dx > 0) ? longint'(my) : -longint'(my);
            end
            strip_expect.insert(strip_expect.size(), strip_vtx(px, py, last_color, 1'b0));
            strip_expect.insert(strip_expect.size(),
                                strip_vtx(clamp_coord(px + offx), clamp_coord(py + offy),
                                          last_color, 1'b0));
            strip_expect.insert(strip_expect.size(), strip_vtx(cx, cy, v.color, 1'b0));
            strip_expect.insert(strip_expect.size(),
                                strip_vtx(clamp_coord(cx + offx), clamp_coord(cy + offy),
                                          v.color, 1'b1));
        end
        last_x = v.x;
        last_y = v.y;
        last_color = v.color;
        have_prev = !v.ends;
    endfunction

    task automatic add_vertex(input longint x, input longint y, input logic [31:0] color,
                              input logic ends);
        vertex_t v;
        v.x = x[COORD_BITS-1:0];
        v.y = y[COORD_BITS-1:0];
        v.color = color;
        v.ends = ends;
        vertex_queue.insert(vertex_queue.size(), v);
    endtask

    // Next coordinate of a polyline: mostly steps of assorted size, sometimes wild.
    function automatic longint next_coord(input longint prev);
        logic [COORD_BITS-1:0] raw;
        longint                step;
        raw = COORD_BITS'($urandom);
        step = 0;
        case ($urandom_range(0, 9))
            0: return longint'($signed(raw));
            1: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            2, 3, 4: step = longint'($urandom_range(0, 1024)) - 512;
            5, 6, 7, 8: step = longint'($urandom_range(0, 80000)) - 40000;
            default: step = longint'($urandom_range(0, 1 << COORD_BITS)) - COORD_MAX;
        endcase
        return clamp_coord(prev + step);
    endfunction

    // Random polylines of one to eight vertices; some vertices repeat the previous one.
    task automatic queue_random_polylines(input int n_items);
        int     made;
        int     run_len;
        longint px;
        longint py;
        made = 0;
        px = 0;
        py = 0;
        while (made < n_items)
        begin
            run_len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
            for (int k = 0; k < run_len && made < n_items; k++)
            begin
                if (k == 0 || $urandom_range(0, 11) != 0)
                begin
                    px = next_coord(px);
                    py = next_coord(py);
                end
                add_vertex(px, py, $urandom, k == run_len - 1);
                made++;
            end
        end
    endtask

    // Wait until every queued vertex is taken and every strip vertex has come out.
    task automatic drain_strips();
        do
            @(negedge clk);
        while (vertex_queue.size() != 0 || s_tvalid || strip_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_stroke_width(input logic [15:0] w);
        cfg_we <= 1'b1;
        cfg_wdata <= w;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Input driver: one vertex per beat, random gap between them.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || src_fire))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (vertex_queue.size() > 0)
            begin
                pending = vertex_queue.pop_front();
                s_tdata <= {pending.color, pending.y, pending.x};
                s_tlast <= pending.ends;
                s_tvalid <= 1'b1;
                src_gap = src_idle_en ? $urandom_range(0, 15) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output receiver: random stall after each beat, plus requested long hold-offs.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_fire)
                snk_wait = snk_idle_en ? $urandom_range(0, 15) : 0;
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predict on each input beat and check each output beat.
    always @(posedge clk)
    begin
        src_fire = rst_n && s_tvalid && s_tready;
        snk_fire = rst_n && m_tvalid && m_tready;
        if (rst_n && cfg_we)
            stroke_w = cfg_wdata;
        if (src_fire)
        begin
            seen_vtx.x = s_tdata[COORD_BITS-1:0];
            seen_vtx.y = s_tdata[2*COORD_BITS-1:COORD_BITS];
            seen_vtx.color = s_tdata[2*COORD_BITS+31:2*COORD_BITS];
            seen_vtx.ends = s_tlast;
            extrude_vertex(seen_vtx);
        end
        if (snk_fire)
        begin
            if (strip_expect.size() == 0)
            begin
                $display("%0t: unexpected strip vertex, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end
            else
            begin
                want = strip_expect.pop_front();
                if (m_tdata[COORD_BITS-1:0] !== want.x)
                begin
                    $display("%0t: out_x expected %h got %h", $time, want.x,
                             m_tdata[COORD_BITS-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y)
                begin
                    $display("%0t: out_y expected %h got %h", $time, want.y,
                             m_tdata[2*COORD_BITS-1:COORD_BITS]);
                    mismatch_count++;
                end
                if (m_tdata[2*COORD_BITS+31:2*COORD_BITS] !== want.color)
                begin
                    $display("%0t: out_color expected %h got %h", $time, want.color,
                             m_tdata[2*COORD_BITS+31:2*COORD_BITS]);
                    mismatch_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: run_last expected %b got %b", $time, want.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (src_fire || snk_fire)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Stimulus sequence: directed vertices, then random polylines under several widths.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width: lone vertex, axis steps, zero-length segment, extreme corners.
        add_vertex(0, 0, 32'h0000_0000, 1'b1);
        add_vertex(0, 0, 32'hFFFF_FFFF, 1'b0);
        add_vertex(256, 0, 32'h0000_0000, 1'b0);
        add_vertex(256, 256, 32'hFFFF_FFFF, 1'b0);
        add_vertex(256, 256, $urandom, 1'b0);
        add_vertex(-256, -256, $urandom, 1'b0);
        add_vertex(COORD_MAX, COORD_MAX, $urandom, 1'b0);
        add_vertex(COORD_MIN, COORD_MIN, $urandom, 1'b0);
        add_vertex(COORD_MAX, COORD_MIN, $urandom, 1'b0);
        add_vertex(COORD_MIN, COORD_MAX, $urandom, 1'b1);
        drain_strips();

        // Zero width: offset vertices coincide with the originals.
        set_stroke_width(16'd0);
        add_vertex(100, 100, $urandom, 1'b0);
        add_vertex(-5000, 77, $urandom, 1'b1);
        queue_random_polylines(40);
        drain_strips();

        // Widest stroke next to the coordinate limits, so offsets saturate.
        set_stroke_width(16'hFFFF);
        add_vertex(COORD_MAX - 10, 0, $urandom, 1'b0);
        add_vertex(COORD_MAX - 10, -300, $urandom, 1'b0);
        add_vertex(COORD_MIN + 5, COORD_MIN + 100, $urandom, 1'b0);
        add_vertex(COORD_MIN + 5, COORD_MIN + 20, $urandom, 1'b1);
        queue_random_polylines(60);
        drain_strips();

        // Random width while the receiver holds off and the block backs up.
        set_stroke_width(16'($urandom));
        @(posedge clk);
        queue_random_polylines(90);
        hold_requests++;
        drain_strips();

        // Narrowest nonzero stroke with both sides running flat out.
        set_stroke_width(16'd1);
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        queue_random_polylines(40);
        drain_strips();

        set_stroke_width(16'($urandom));
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
        queue_random_polylines(50);
        drain_strips();

        if (mismatch_count == 0 && strip_expect.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/pwe_pkg.sv
hdl/pwe_ctrl.sv
hdl/pwe_datapath.sv
hdl/polyline_width_extruder_top.sv
dv/tb_top.sv
